FILE: rtl/md5sh_pkg.sv
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types and constants for the MD5 stream hasher: command and status
// groups, chaining-word initial values, round constants and helpers.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam logic [31:0] CHAIN_A0 = 32'h67452301;
    localparam logic [31:0] CHAIN_B0 = 32'hefcdab89;
    localparam logic [31:0] CHAIN_C0 = 32'h98badcfe;
    localparam logic [31:0] CHAIN_D0 = 32'h10325476;

    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam logic [5:0]  LAST_BYTE = 6'd63;
    localparam logic [5:0]  LEN_POS   = 6'd56;

    localparam logic [31:0] ADD_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // indexed by {stage, round[1:0]}
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic byte_wr;     // store the incoming byte, bump the count
        logic pad;         // 0x80 mark, zero fill, length if it fits
        logic len_wr;      // zero block, write length words
        logic load;        // work regs <= chain, round 0
        logic round;       // one compression round
        logic chain_add;   // chain += work regs
        logic chain_init;  // back to initial chain, count cleared
    } md5sh_cmd_t;

    typedef struct packed {
        logic blk_last_byte;  // next byte fills the block
        logic pad_two;        // length will not fit after the pad mark
        logic round_last;     // round 63 in progress
    } md5sh_stat_t;

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] k;
        logic [3:0] g;
        begin
            k = rnd[3:0];
            unique case (rnd[5:4])
                2'd0: g = k;
                2'd1: g = 4'((k << 2) + k + 4'd1);
                2'd2: g = 4'((k << 1) + k + 4'd5);
                2'd3: g = 4'((k << 3) - k);
            endcase
            msg_index = g;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            unique case (stage)
                2'd0: f = (b & c) | (~b & d);
                2'd1: f = (b & d) | (c & ~d);
                2'd2: f = b ^ c ^ d;
                2'd3: f = c ^ (b | ~d);
            endcase
            round_f = f;
        end
    endfunction

endpackage

FILE: rtl/md5sh_dp.sv
// ----------------------------------------------------------------------------
// md5sh_dp
// Datapath: block buffer, byte counter, chaining words, round registers and
// the single round unit with a one-round-ahead message/constant prefetch.
// ----------------------------------------------------------------------------
module md5sh_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  md5sh_pkg::md5sh_cmd_t    cmd,
    output md5sh_pkg::md5sh_stat_t   stat,
    input  logic [7:0]               data_byte,
    input  logic [1:0]               word_index,
    output logic [31:0]              digest_word
);

    logic [3:0][7:0] block_reg  [16];
    logic [3:0][7:0] block_next [16];
    logic [31:0]     chain_reg  [4];
    logic [31:0]     work_reg   [4];
    logic [31:0]     count_reg;
    logic [31:0]     wk_reg;
    logic [31:0]     wk_next;
    logic [5:0]      round_reg;
    logic [5:0]      round_inc;
    logic [5:0]      fetch_idx;
    logic [5:0]      pos;
    logic [1:0]      stage;
    logic [31:0]     f_val;
    logic [31:0]     sum;
    logic [63:0]     rot_dbl;
    logic [31:0]     t_val;

    assign pos = count_reg[5:0];

    // block buffer update: byte store, padding, length words
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                logic [5:0] bp;
                bp = 6'(w * 4 + l);
                block_next[w][l] = block_reg[w][l];
                if (cmd.byte_wr && bp == pos)
                    block_next[w][l] = data_byte;
                else if (cmd.pad && bp == pos)
                    block_next[w][l] = md5sh_pkg::PAD_MARK;
                else if (cmd.pad && bp > pos)
                    block_next[w][l] = 8'h00;
                else if (cmd.len_wr)
                    block_next[w][l] = 8'h00;
            end
        end
        if ((cmd.pad && !stat.pad_two) || cmd.len_wr)
        begin
            block_next[14] = {count_reg[28:0], 3'b000};
            block_next[15] = {29'd0, count_reg[31:29]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < 16; w++)
            block_reg[w] <= block_next[w];
    end

    // one round
    assign stage   = round_reg[5:4];
    assign f_val   = md5sh_pkg::round_f(stage, work_reg[1], work_reg[2], work_reg[3]);
    assign sum     = work_reg[0] + f_val + wk_reg;
    assign rot_dbl = {sum, sum} << md5sh_pkg::ROT_AMT[{stage, round_reg[1:0]}];
    assign t_val   = rot_dbl[63:32] + work_reg[1];

    assign round_inc = round_reg + 6'd1;
    assign fetch_idx = cmd.load ? 6'd0 : round_inc;
    assign wk_next   = block_reg[md5sh_pkg::msg_index(fetch_idx)]
                     + md5sh_pkg::ADD_CONST[fetch_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 4; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            work_reg[0] <= work_reg[3];
            work_reg[1] <= t_val;
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
        end
        if (cmd.load || cmd.round)
            wk_reg <= wk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg    <= 6'd0;
            count_reg    <= 32'd0;
            chain_reg[0] <= md5sh_pkg::CHAIN_A0;
            chain_reg[1] <= md5sh_pkg::CHAIN_B0;
            chain_reg[2] <= md5sh_pkg::CHAIN_C0;
            chain_reg[3] <= md5sh_pkg::CHAIN_D0;
        end
        else
        begin
            if (cmd.load)
                round_reg <= 6'd0;
            else if (cmd.round)
                round_reg <= round_inc;

            if (cmd.chain_init)
                count_reg <= 32'd0;
            else if (cmd.byte_wr)
                count_reg <= count_reg + 32'd1;

            if (cmd.chain_init)
            begin
                chain_reg[0] <= md5sh_pkg::CHAIN_A0;
                chain_reg[1] <= md5sh_pkg::CHAIN_B0;
                chain_reg[2] <= md5sh_pkg::CHAIN_C0;
                chain_reg[3] <= md5sh_pkg::CHAIN_D0;
            end
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < 4; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    assign stat.blk_last_byte = (pos == md5sh_pkg::LAST_BYTE);
    assign stat.pad_two       = (pos >= md5sh_pkg::LEN_POS);
    assign stat.round_last    = (round_reg == md5sh_pkg::LAST_BYTE);

    assign digest_word = chain_reg[word_index];

    // round counter wraps to zero after the last round
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.round && !cmd.load && round_reg == md5sh_pkg::LAST_BYTE) |=> round_reg == 6'd0)
        else $error("round counter did not wrap after round 63");

    a_chain_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chain_init |=> (chain_reg[0] == md5sh_pkg::CHAIN_A0 && count_reg == 32'd0))
        else $error("chain or byte count not restored");

endmodule

FILE: rtl/md5sh_ctrl.sv
// ----------------------------------------------------------------------------
// md5sh_ctrl
// Controller: byte intake, padding steps, compression sequencing and
// delivery of the four digest words.
// ----------------------------------------------------------------------------
module md5sh_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_valid,
    input  logic                     s_byte_valid,
    input  logic                     s_last,
    output logic                     s_ready,
    output logic                     m_valid,
    output logic                     m_last,
    input  logic                     m_ready,
    output logic [1:0]               word_index,
    output md5sh_pkg::md5sh_cmd_t    cmd,
    input  md5sh_pkg::md5sh_stat_t   stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_LEN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // where to go once a compression is folded into the chain
    localparam logic [1:0] AFTER_IDLE = 2'd0;
    localparam logic [1:0] AFTER_PAD  = 2'd1;
    localparam logic [1:0] AFTER_LEN  = 2'd2;
    localparam logic [1:0] AFTER_OUT  = 2'd3;

    localparam logic [1:0] LAST_WORD = 2'd3;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] after_reg;
    logic [1:0] after_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       s_hs;
    logic       m_hs;

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = (state_reg == S_OUT);
    assign m_last     = (idx_reg == LAST_WORD);
    assign word_index = idx_reg;
    assign s_hs       = s_valid && s_ready;
    assign m_hs       = m_valid && m_ready;

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_hs)
                begin
                    cmd.byte_wr = s_byte_valid;
                    if (s_byte_valid && stat.blk_last_byte)
                    begin
                        state_next = S_LOAD;
                        after_next = s_last ? AFTER_PAD : AFTER_IDLE;
                    end
                    else if (s_last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.pad    = 1'b1;
                state_next = S_LOAD;
                after_next = stat.pad_two ? AFTER_LEN : AFTER_OUT;
            end
            S_LEN:
            begin
                cmd.len_wr = 1'b1;
                state_next = S_LOAD;
                after_next = AFTER_OUT;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.round_last)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                unique case (after_reg)
                    AFTER_IDLE: state_next = S_IDLE;
                    AFTER_PAD:  state_next = S_PAD;
                    AFTER_LEN:  state_next = S_LEN;
                    AFTER_OUT:  state_next = S_OUT;
                endcase
            end
            S_OUT:
            begin
                if (m_hs)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        cmd.chain_init = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= AFTER_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            idx_reg   <= idx_next;
        end
    end

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && stat.round_last) |=> state_reg == S_ADD)
        else $error("compression did not end after round 63");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_hs && m_last) |=> (state_reg == S_IDLE && idx_reg == 2'd0))
        else $error("controller not back to intake after final digest word");

endmodule

FILE: rtl/md5_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher_core
// MD5 digest of a byte stream: bytes in, four 32-bit digest words out.
// ----------------------------------------------------------------------------
// Throughput: one byte a cycle while a block fills; the 64th byte of a block
//   holds intake for chain load, 64 rounds on one round unit, chain add.
// Closing item: pad step, then a compression; when the length does not fit
//   after the pad mark, a length step and a second block compression follow.
// Reset: chain words to the MD5 initial values, byte count to zero, idle.
// ----------------------------------------------------------------------------
module md5_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    // digest words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    md5sh_pkg::md5sh_cmd_t  cmd;
    md5sh_pkg::md5sh_stat_t stat;
    logic [1:0]             word_index;

    // Sequencer: the only place that watches the handshakes. It issues one
    // command group per cycle to the datapath.
    md5sh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_axis_tvalid),
        .s_byte_valid (s_axis_tuser),
        .s_last       (s_axis_tlast),
        .s_ready      (s_axis_tready),
        .m_valid      (m_axis_tvalid),
        .m_last       (m_axis_tlast),
        .m_ready      (m_axis_tready),
        .word_index   (word_index),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Datapath: the byte of an accepted item with byte_valid set is stored
    // straight from the port; the digest word reads the (stable) chain regs.
    md5sh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (s_axis_tdata),
        .word_index  (word_index),
        .digest_word (m_axis_tdata)
    );

    assign m_axis_tuser = word_index;

endmodule

FILE: test/md5_stream_hasher_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_core_test
// Self-checking bench for the MD5 stream hasher. A short table of hand-picked
// items (known digests, empty messages, noise items, extreme bytes) is
// followed by random messages that include lengths around the block and
// padding boundaries. Every digest word is checked against the known digest
// or a behavioural MD5 model kept in this file. The input side sends in bursts
// and the output side stalls on a rolling pattern.
// ----------------------------------------------------------------------------
module md5_stream_hasher_core_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 100;

    // MD5 initial chaining values, round constants and rotate amounts
    localparam logic [31:0] MD5_IV [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };
    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int MD5_ROT [16] = '{
        7, 12, 17, 22,  5, 9, 14, 20,  4, 11, 16, 23,  6, 10, 15, 21
    };
    localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
    localparam int         MD5_LEN_POS  = 56;

    // one digest word as the block should present it
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_item_t;

    // directed item: digest given in the usual hex form, byte 0 leftmost
    typedef struct packed {
        logic [7:0]   data;
        logic         has_byte;
        logic         closes;
        logic         known;
        logic [127:0] digest;
    } vector_t;

    localparam int N_VECTORS = 17;

    vector_t plan [N_VECTORS] = '{
        // empty message straight after reset
        '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e},
        // neither byte nor end: ignored
        '{8'hff, 1'b0, 1'b0, 1'b0, 128'h0},
        // "abc", closed on the last byte
        '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72},
        // chain must be back at its initial value: empty again
        '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e},
        // "a"
        '{8'h61, 1'b1, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661},
        // extreme single bytes
        '{8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
        // noise before a message, message closed by an empty end marker
        '{8'haa, 1'b0, 1'b0, 1'b0, 128'h0},
        '{8'h55, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h01, 1'b0, 1'b1, 1'b0, 128'h0},
        // noise in the middle of a message
        '{8'hfe, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0},
        '{8'h5a, 1'b1, 1'b1, 1'b0, 128'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] byte_valid
    logic        s_axis_tlast = 1'b0;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic [1:0]  m_axis_tuser;          // [1:0] word_index
    logic        m_axis_tlast;          // last_word

    md5_stream_hasher_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // MD5 model state: chain, current 64-byte block, message byte count
    // ------------------------------------------------------------------------
    logic [31:0]  md5_chain [4];
    logic [7:0]   md5_block [64];
    logic [31:0]  md5_count;

    digest_item_t digest_words_due [$];
    digest_item_t head_due;
    int           fails = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    logic [7:0]   stall_pattern = 8'hff;
    logic [4:0]   stall_phase = '0;

    task automatic md5_restart();
        md5_chain = MD5_IV;
        md5_count = '0;
    endtask

    // 64 rounds over the current block, then add into the chain
    task automatic md5_compress();
        logic [31:0] msg [16];
        logic [31:0] a, b, c, d, f, t;
        int          g, k, stage, s;
        for (int i = 0; i < 16; i++)
            msg[i] = {md5_block[4*i+3], md5_block[4*i+2], md5_block[4*i+1], md5_block[4*i]};
        a = md5_chain[0];
        b = md5_chain[1];
        c = md5_chain[2];
        d = md5_chain[3];
        for (int r = 0; r < 64; r++)
        begin
            stage = r / 16;
            k     = r % 16;
            case (stage)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = k;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * k + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * k + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * k) % 16;
                end
            endcase
            t = a + f + msg[g] + MD5_K[r];
            s = MD5_ROT[stage * 4 + k % 4];
            t = ((t << s) | (t >> (32 - s))) + b;
            a = d;
            d = c;
            c = b;
            b = t;
        end
        md5_chain[0] += a;
        md5_chain[1] += b;
        md5_chain[2] += c;
        md5_chain[3] += d;
    endtask

    // Takes one accepted item; on a closing item pads, appends the 64-bit
    // bit length, compresses and hands back the four digest words.
    task automatic md5_absorb_item(input logic [7:0] data, input logic has_byte,
                                   input logic closes, output logic [31:0] digest_out [4]);
        int          pos;
        logic [63:0] bit_len;
        if (has_byte)
        begin
            md5_block[md5_count[5:0]] = data;
            md5_count++;
            if (md5_count[5:0] == 6'd0)
                md5_compress();
        end
        if (closes)
        begin
            pos = int'(md5_count[5:0]);
            md5_block[pos] = MD5_PAD_BYTE;
            for (int p = pos + 1; p < 64; p++)
                md5_block[p] = 8'h00;
            // no room for the length after the pad byte: extra block
            if (pos >= MD5_LEN_POS)
            begin
                md5_compress();
                for (int p = 0; p < 64; p++)
                    md5_block[p] = 8'h00;
            end
            bit_len = {32'd0, md5_count} << 3;
            for (int j = 0; j < 8; j++)
                md5_block[MD5_LEN_POS + j] = bit_len[8*j +: 8];
            md5_compress();
            digest_out = md5_chain;
            md5_restart();
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side: bursts of back-to-back items with random gaps between them.
    // Expectations are queued at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic closes,
                             input logic known, input logic [127:0] digest);
        logic [31:0]  words [4];
        logic [31:0]  typed;
        digest_item_t due;
        int           gap;
        @(negedge clk);
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= has_byte;
        s_axis_tlast  <= closes;
        do
            @(posedge clk);
        while (!s_axis_tready);

        md5_absorb_item(data, has_byte, closes, words);
        if (closes)
        begin
            for (int i = 0; i < 4; i++)
            begin
                // hex digest: byte 4i+j of the string is byte j of word i
                for (int j = 0; j < 4; j++)
                    typed[8*j +: 8] = digest[127 - 8*(4*i + j) -: 8];
                due.word  = known ? typed : words[i];
                due.index = 2'(i);
                due.last  = (i == 3);
                digest_words_due.push_back(due);
            end
        end
    endtask

    // Output side: 8-bit ready pattern repeated, reloaded when the 5-bit
    // phase counter wraps; a quarter of the windows never stall.
    always @(negedge clk)
    begin
        if (stall_phase == 5'd0)
            stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        m_axis_tready <= stall_pattern[stall_phase[2:0]];
        stall_phase = stall_phase + 5'd1;
    end

    // Digest checker: each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_words_due.size() == 0)
            begin
                $display("%0t: unexpected digest item %h idx %0d last %0b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fails++;
            end
            else
            begin
                head_due = digest_words_due.pop_front();
                if (m_axis_tdata !== head_due.word || m_axis_tuser !== head_due.index ||
                    m_axis_tlast !== head_due.last)
                begin
                    $display("%0t: digest mismatch, expected %h idx %0d last %0b, got %h idx %0d last %0b",
                             $time, head_due.word, head_due.index, head_due.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d digest words outstanding", $time,
                     digest_words_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int         boundary_len [$];
        int         len;
        int         pick;
        int         random_items;
        logic       by_marker;
        vector_t    v;

        md5_restart();
        // length at the padding limit (second block) and a full block
        boundary_len = '{56, 64};
        random_items = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < N_VECTORS; n++)
        begin
            v = plan[n];
            send_item(v.data, v.has_byte, v.closes, v.known, v.digest);
        end

        // random messages; the boundary lengths are mixed in at random points
        while (random_items < RANDOM_ITEMS || boundary_len.size() != 0)
        begin
            if (boundary_len.size() != 0 &&
                (random_items >= RANDOM_ITEMS || $urandom_range(0, 2) == 0))
            begin
                pick = $urandom_range(0, boundary_len.size() - 1);
                len  = boundary_len[pick];
                boundary_len.delete(pick);
            end
            else
                len = $urandom_range(0, 12);

            // close either on the last byte or with an empty end marker
            by_marker = (len == 0) || ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
                send_item(8'($urandom), 1'b1, (i == len - 1) && !by_marker, 1'b0, '0);
            end
            if (by_marker)
                send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
            random_items += len + int'(by_marker);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (digest_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/md5sh_pkg.sv
rtl/md5sh_dp.sv
rtl/md5sh_ctrl.sv
rtl/md5_stream_hasher_core.sv
test/md5_stream_hasher_core_test.sv
